// ===== rtl/gpb_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO port register block package
// Shared types, register offsets and per-port constant tables.
// ----------------------------------------------------------------------------
`default_nettype none

package gpb_pkg;

  // Largest number of ports the address map can hold (address / 0x20).
  localparam int unsigned MaxPorts        = 8;
  localparam int unsigned NumPortsDefault = 6;

  // Request function codes.
  typedef enum logic [1:0] {
    FuncRead  = 2'd0,
    FuncWrite = 2'd1,
    FuncPad   = 2'd2
  } func_e;

  // Register word index within a port window (offset bits [4:2]).
  localparam logic [2:0] RegDir  = 3'd0;
  localparam logic [2:0] RegMask = 3'd4;
  localparam logic [2:0] RegPin  = 3'd5;
  localparam logic [2:0] RegSet  = 3'd6;
  localparam logic [2:0] RegClr  = 3'd7;

  // Access size codes.
  localparam logic [2:0] SizeByte = 3'd1;
  localparam logic [2:0] SizeHalf = 3'd2;

  // Pads driven by the board read the pad level regardless of direction.
  localparam logic [31:0] Port0Board = 32'h1A00_3712;
  localparam logic [31:0] Port2Board = 32'h0000_0400;
  localparam logic [31:0] Port3Board = 32'hFFC0_0000;

  // One request as registered at the input.
  typedef struct packed {
    func_e       func;
    logic [7:0]  bus_address;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic [2:0]  pad_port;
    logic [4:0]  pad_bit;
    logic        pad_level;
  } req_t;

  // One result as produced by the register file.
  typedef struct packed {
    logic [31:0] read_data;
    logic        change_notify;
    logic        bad_offset;
  } rsp_t;

  // Pad level after reset: pull-ups everywhere except no-pull pads.
  function automatic logic [31:0] pad_reset(input logic [2:0] port);
    logic [31:0] val;
    case (port)
      3'd0:    val = 32'h1DFF_CC7F;
      3'd3:    val = 32'hF7FF_FFFF;
      3'd5:    val = 32'hFFFF_FFF3;
      default: val = 32'hFFFF_FFFF;
    endcase
    return val;
  endfunction

  // Board-driven pad mask of a port.
  function automatic logic [31:0] board_mask(input logic [2:0] port);
    logic [31:0] val;
    case (port)
      3'd0:    val = Port0Board;
      3'd2:    val = Port2Board;
      3'd3:    val = Port3Board;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

  // Byte-lane mask of an access before the lane shift.
  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] val;
    case (size)
      SizeByte: val = 32'h0000_00FF;
      SizeHalf: val = 32'h0000_FFFF;
      default:  val = 32'hFFFF_FFFF;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gpb_regfile.sv =====
// ----------------------------------------------------------------------------
// GPIO port register file
// Holds direction, mask, output latch and pad level words of every port,
// applies one registered request per cycle and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module gpb_regfile #(
  parameter int unsigned NUM_PORTS = gpb_pkg::NumPortsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  wire gpb_pkg::req_t req_i,
  output gpb_pkg::rsp_t      rsp_o
);
  import gpb_pkg::*;

  logic [2:0]  bus_port;
  logic [2:0]  reg_idx;
  logic [4:0]  lane_shift;
  logic [31:0] smask;
  logic [31:0] lane;
  logic [31:0] bits;
  logic        port_ok;
  logic        is_read;
  logic        is_write;
  logic        is_pad;
  logic        bad;
  logic        write_notify;
  logic [NUM_PORTS-1:0] pad_changed;
  logic [31:0] rd_word [NUM_PORTS];
  logic [31:0] rd_any;

  // Address decode and lane alignment shared by all ports.
  assign bus_port   = req_i.bus_address[7:5];
  assign reg_idx    = req_i.bus_address[4:2];
  assign lane_shift = {req_i.bus_address[1:0], 3'b000};
  assign smask      = size_mask(req_i.access_size);
  assign lane       = smask << lane_shift;
  assign bits       = (req_i.write_data << lane_shift) & lane;
  assign port_ok    = {1'b0, bus_port} < 4'(NUM_PORTS);
  assign is_read    = req_valid_i && (req_i.func == FuncRead);
  assign is_write   = req_valid_i && (req_i.func == FuncWrite);
  assign is_pad     = req_valid_i && (req_i.func == FuncPad);

  // Write classification: notifying registers and reserved offsets.
  always_comb begin
    bad          = 1'b0;
    write_notify = 1'b0;
    if (is_write && port_ok) begin
      unique case (reg_idx)
        RegDir, RegPin, RegSet, RegClr: write_notify = 1'b1;
        RegMask:                        write_notify = 1'b0;
        default:                        bad          = 1'b1;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_port
    logic [31:0] dir_q, dir_d;
    logic [31:0] mask_q, mask_d;
    logic [31:0] latch_q, latch_d;
    logic [31:0] pad_q, pad_d;
    logic [31:0] affect;
    logic [31:0] pad_val;
    logic [31:0] board;
    logic        wr_sel;
    logic        pad_sel;

    assign wr_sel  = is_write && (bus_port == 3'(g));
    assign pad_sel = is_pad && (req_i.pad_port == 3'(g));
    assign affect  = ~mask_q & lane;
    assign board   = board_mask(3'(g));

    // Bus writes to this port's registers.
    always_comb begin
      dir_d   = dir_q;
      mask_d  = mask_q;
      latch_d = latch_q;
      if (wr_sel) begin
        unique case (reg_idx)
          RegDir:  dir_d   = (dir_q & ~lane) | bits;
          RegMask: mask_d  = (mask_q & ~lane) | bits;
          RegPin:  latch_d = (latch_q & ~affect) | (bits & affect);
          RegSet:  latch_d = latch_q | (bits & affect);
          RegClr:  latch_d = latch_q & ~(bits & affect);
          default: latch_d = latch_q;
        endcase
      end
    end

    // Pad level events.
    always_comb begin
      pad_d = pad_q;
      if (pad_sel) begin
        pad_d[req_i.pad_bit] = req_i.pad_level;
      end
    end
    assign pad_changed[g] = pad_sel && (pad_q[req_i.pad_bit] != req_i.pad_level);

    // Pad value: latch where driven, pad level elsewhere and on board pads.
    assign pad_val = (((latch_q & dir_q) | (pad_q & ~dir_q)) & ~board) | (pad_q & board);

    // Read word of this port, zero unless it is addressed.
    always_comb begin
      rd_word[g] = '0;
      if (bus_port == 3'(g)) begin
        unique case (reg_idx)
          RegDir:         rd_word[g] = dir_q;
          RegMask:        rd_word[g] = mask_q;
          RegPin, RegSet: rd_word[g] = pad_val;
          default:        rd_word[g] = '0;
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dir_q   <= '0;
        mask_q  <= '0;
        latch_q <= '0;
        pad_q   <= pad_reset(3'(g));
      end else begin
        dir_q   <= dir_d;
        mask_q  <= mask_d;
        latch_q <= latch_d;
        pad_q   <= pad_d;
      end
    end
  end

  // Combine the per-port read words; only one port can be addressed.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      rd_any = rd_any | rd_word[i];
    end
  end

  // Result of the current request.
  always_comb begin
    rsp_o.read_data     = is_read ? ((rd_any >> lane_shift) & smask) : '0;
    rsp_o.change_notify = write_notify || (|pad_changed);
    rsp_o.bad_offset    = bad;
  end

  // A reserved-offset write never notifies.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.bad_offset |-> !rsp_o.change_notify)
    else $error("bad offset write also flagged a change");

  // Writes and pad events never return read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_read |-> (rsp_o.read_data == '0))
    else $error("read data returned for a non-read request");

  // A pad event that reports a change must alter some pad word next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_pad && rsp_o.change_notify) |=> $past(|pad_changed))
    else $error("pad change reported without a pad word update");

endmodule

`default_nettype wire

// ===== rtl/gpio_port_register_block_core.sv =====
// ----------------------------------------------------------------------------
// GPIO port register block core
// Multi-port GPIO register file with bus access and pad level events.
// ----------------------------------------------------------------------------
// No request is ever refused: busy_o stays low and a new request may
// follow start_i in each cycle. A request is registered at the input,
// applied to the port registers in the next cycle, and its result, held
// in the result register, appears on the result ports with done_o high
// for exactly one cycle. The receiver cannot stall the result; it must
// take it in that cycle. Requests take effect strictly in order, so a
// read issued right after a write sees the written value.
`default_nettype none

module gpio_port_register_block_core #(
  parameter int unsigned NUM_PORTS = gpb_pkg::NumPortsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  bus_address_i,
  input  wire logic [2:0]  access_size_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [2:0]  pad_port_i,
  input  wire logic [4:0]  pad_bit_i,
  input  wire logic        pad_level_i,
  output logic             done_o,
  output logic [31:0]      read_data_o,
  output logic             change_notify_o,
  output logic             bad_offset_o
);
  import gpb_pkg::*;

  logic  req_valid_q;
  req_t  req_q, req_d;
  rsp_t  rsp;
  logic  done_q;
  rsp_t  rsp_q;

  // The block takes a request every cycle.
  assign busy_o = 1'b0;

  // Input request capture.
  always_comb begin
    req_d.func        = func_e'(func_i);
    req_d.bus_address = bus_address_i;
    req_d.access_size = access_size_i;
    req_d.write_data  = write_data_i;
    req_d.pad_port    = pad_port_i;
    req_d.pad_bit     = pad_bit_i;
    req_d.pad_level   = pad_level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_d;
    end
  end

  gpb_regfile #(
    .NUM_PORTS(NUM_PORTS)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_q),
    .req_i      (req_q),
    .rsp_o      (rsp)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q <= rsp;
    end
  end

  assign done_o          = done_q;
  assign read_data_o     = done_q ? rsp_q.read_data : '0;
  assign change_notify_o = done_q && rsp_q.change_notify;
  assign bad_offset_o    = done_q && rsp_q.bad_offset;

  // Every registered request produces exactly one result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> done_o)
    else $error("registered request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |=> !done_o)
    else $error("result without a registered request");

  // A result follows each accepted request through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##2 done_o)
    else $error("accepted request did not complete in two cycles");

endmodule

`default_nettype wire

// ===== tb/sv/gpio_port_register_block_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO port register block core testbench
// Sends bus reads, bus writes and pad level events. It predicts every
// result from a local copy of the port registers and compares each
// result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

module gpio_port_register_block_core_tb;
  import gpb_pkg::*;

  localparam int unsigned NumPorts    = 6;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 820;
  localparam int unsigned MaxPrinted  = 40;

  // Codes that the package does not name.
  localparam logic [1:0] FuncSpare    = 2'd3;
  localparam logic [2:0] RegRsv1      = 3'd1;
  localparam logic [2:0] RegRsv2      = 3'd2;
  localparam logic [2:0] RegRsv3      = 3'd3;
  localparam logic [2:0] SizeWord     = 3'd4;
  localparam logic [2:0] SizeCodeZero = 3'd0;
  localparam logic [2:0] SizeCodeMax  = 3'd7;

  // Pad levels after reset, pull-ups except on the no-pull pads.
  localparam logic [31:0] PadPullups [MaxPorts] = '{
    32'h1DFF_CC7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hF7FF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFF3, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic [1:0]  func_i          = '0;
  logic [7:0]  bus_address_i   = '0;
  logic [2:0]  access_size_i   = '0;
  logic [31:0] write_data_i    = '0;
  logic [2:0]  pad_port_i      = '0;
  logic [4:0]  pad_bit_i       = '0;
  logic        pad_level_i     = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] read_data_o;
  logic        change_notify_o;
  logic        bad_offset_o;

  // Local copy of the port registers.
  logic [31:0] dir_words   [MaxPorts];
  logic [31:0] mask_words  [MaxPorts];
  logic [31:0] out_latches [MaxPorts];
  logic [31:0] pad_words   [MaxPorts];

  rsp_t        pending_rsps[$];
  int unsigned n_errors     = 0;
  int unsigned n_requests   = 0;
  int unsigned n_results    = 0;
  int unsigned n_reads      = 0;
  int unsigned n_writes     = 0;
  int unsigned n_pad_events = 0;
  int unsigned n_notifies   = 0;
  int unsigned n_bad_writes = 0;
  int unsigned burst_left   = 0;
  int unsigned idle_count   = 0;

  gpio_port_register_block_core #(
    .NUM_PORTS(NumPorts)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .bus_address_i  (bus_address_i),
    .access_size_i  (access_size_i),
    .write_data_i   (write_data_i),
    .pad_port_i     (pad_port_i),
    .pad_bit_i      (pad_bit_i),
    .pad_level_i    (pad_level_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .change_notify_o(change_notify_o),
    .bad_offset_o   (bad_offset_o)
  );

  always #6 clk_i = ~clk_i;

  // Byte lanes covered by an access, before the lane shift.
  function automatic logic [31:0] access_lanes(input logic [2:0] size);
    logic [31:0] lanes;
    case (size)
      SizeByte: lanes = 32'h0000_00FF;
      SizeHalf: lanes = 32'h0000_FFFF;
      default:  lanes = 32'hFFFF_FFFF;
    endcase
    return lanes;
  endfunction

  // Pads that the board drives; they always show the pad level.
  function automatic logic [31:0] board_driven(input int unsigned port);
    logic [31:0] pads;
    case (port)
      0:       pads = Port0Board;
      2:       pads = Port2Board;
      3:       pads = Port3Board;
      default: pads = '0;
    endcase
    return pads;
  endfunction

  // Value seen at PIN and SET: latch on outputs, pad level on inputs and on board-driven pads.
  function automatic logic [31:0] pin_view(input int unsigned port);
    logic [31:0] mixed;
    logic [31:0] board;
    mixed = (out_latches[port] & dir_words[port]) | (pad_words[port] & ~dir_words[port]);
    board = board_driven(port);
    return (mixed & ~board) | (pad_words[port] & board);
  endfunction

  function automatic logic [7:0] reg_address(input int unsigned port, input logic [2:0] reg_idx,
                                             input logic [1:0] lane);
    logic [2:0] port_bits;
    port_bits = port[2:0];
    return {port_bits, reg_idx, lane};
  endfunction

  // Applies one request to the register copy and returns its result.
  function automatic rsp_t gpio_predict(input req_t r);
    rsp_t        res;
    int unsigned port;
    int unsigned shift;
    logic [2:0]  reg_idx;
    logic [31:0] lane;
    logic [31:0] bits;
    logic [31:0] affect;
    logic [31:0] word;
    logic [31:0] old_level;
    res     = '0;
    port    = 32'(r.bus_address[7:5]);
    reg_idx = r.bus_address[4:2];
    shift   = 32'(r.bus_address[1:0]) * 8;
    lane    = access_lanes(r.access_size) << shift;
    case (r.func)
      FuncRead: begin
        if (port < NumPorts) begin
          case (reg_idx)
            RegDir:         word = dir_words[port];
            RegMask:        word = mask_words[port];
            RegPin, RegSet: word = pin_view(port);
            default:        word = '0;
          endcase
          res.read_data = (word >> shift) & access_lanes(r.access_size);
        end
      end
      FuncWrite: begin
        if (port < NumPorts) begin
          bits   = (r.write_data << shift) & lane;
          affect = ~mask_words[port] & lane;
          case (reg_idx)
            RegDir: begin
              dir_words[port] = (dir_words[port] & ~lane) | bits;
              res.change_notify = 1'b1;
            end
            RegMask: begin
              mask_words[port] = (mask_words[port] & ~lane) | bits;
            end
            RegPin: begin
              out_latches[port] = (out_latches[port] & ~affect) | (bits & affect);
              res.change_notify = 1'b1;
            end
            RegSet: begin
              out_latches[port] = out_latches[port] | (bits & affect);
              res.change_notify = 1'b1;
            end
            RegClr: begin
              out_latches[port] = out_latches[port] & ~(bits & affect);
              res.change_notify = 1'b1;
            end
            default: begin
              res.bad_offset = 1'b1;
            end
          endcase
        end
      end
      FuncPad: begin
        if (r.pad_port < NumPorts) begin
          old_level = pad_words[r.pad_port];
          pad_words[r.pad_port][r.pad_bit] = r.pad_level;
          res.change_notify = (pad_words[r.pad_port] != old_level);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t random_fields();
    req_t r;
    r.func        = func_e'($urandom_range(0, 3));
    r.bus_address = 8'($urandom_range(0, 255));
    r.access_size = 3'($urandom_range(0, 7));
    r.write_data  = $urandom;
    r.pad_port    = 3'($urandom_range(0, 7));
    r.pad_bit     = 5'($urandom_range(0, 31));
    r.pad_level   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MaxPrinted) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Sends one request and holds start for the rest of the burst.
  task automatic send_request(input req_t r);
    int unsigned gap;
    @(negedge clk_i);
    start_i       <= 1'b1;
    func_i        <= r.func;
    bus_address_i <= r.bus_address;
    access_size_i <= r.access_size;
    write_data_i  <= r.write_data;
    pad_port_i    <= r.pad_port;
    pad_bit_i     <= r.pad_bit;
    pad_level_i   <= r.pad_level;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_rsps.push_back(gpio_predict(r));
    n_requests++;
    case (r.func)
      FuncRead:  n_reads++;
      FuncWrite: n_writes++;
      FuncPad:   n_pad_events++;
      default: ;
    endcase
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
      // Idle gap with noise on the write data.
      @(negedge clk_i);
      start_i      <= 1'b0;
      write_data_i <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic bus_op(input logic [1:0] func, input logic [7:0] addr, input logic [2:0] size,
                        input logic [31:0] data);
    req_t r;
    r             = random_fields();
    r.func        = func_e'(func);
    r.bus_address = addr;
    r.access_size = size;
    r.write_data  = data;
    send_request(r);
  endtask

  task automatic pad_op(input logic [2:0] port, input logic [4:0] bit_idx, input logic level);
    req_t r;
    r           = random_fields();
    r.func      = FuncPad;
    r.pad_port  = port;
    r.pad_bit   = bit_idx;
    r.pad_level = level;
    send_request(r);
  endtask

  // Reset values seen through PIN, SET and DIR, and the odd word size codes.
  task automatic test_reset_state();
    bus_op(FuncRead, reg_address(0, RegPin, 0), SizeWord, '0);
    bus_op(FuncRead, reg_address(5, RegSet, 0), SizeWord, '0);
    bus_op(FuncRead, reg_address(0, RegDir, 0), SizeCodeZero, '0);
    bus_op(FuncWrite, reg_address(2, RegDir, 0), SizeCodeMax, 32'hFFFF_FFFF);
    bus_op(FuncRead, reg_address(2, RegDir, 0), SizeCodeMax, '0);
  endtask

  // Byte and halfword lanes, lane overflow, and masked PIN, SET and CLR writes.
  task automatic test_lanes_and_mask();
    bus_op(FuncWrite, reg_address(1, RegDir, 0), SizeWord, 32'hFFFF_0000);
    bus_op(FuncWrite, reg_address(1, RegMask, 1), SizeByte, 32'h0000_00FF);
    bus_op(FuncWrite, reg_address(1, RegPin, 0), SizeWord, 32'hA5A5_A5A5);
    bus_op(FuncWrite, reg_address(1, RegSet, 2), SizeHalf, 32'h0000_FFFF);
    bus_op(FuncWrite, reg_address(1, RegClr, 3), SizeByte, 32'h0000_00F0);
    bus_op(FuncRead, reg_address(1, RegPin, 3), SizeHalf, '0);
    bus_op(FuncRead, reg_address(1, RegMask, 1), SizeByte, '0);
    bus_op(FuncWrite, reg_address(4, RegDir, 3), SizeWord, 32'hFFFF_FFFF);
    bus_op(FuncRead, reg_address(4, RegDir, 0), SizeWord, '0);
  endtask

  // Reserved offsets, the CLR read, and ports past the last one.
  task automatic test_reserved_and_ports();
    bus_op(FuncRead, reg_address(1, RegClr, 0), SizeWord, '0);
    bus_op(FuncWrite, reg_address(2, RegRsv1, 0), SizeWord, 32'hFFFF_FFFF);
    bus_op(FuncWrite, reg_address(5, RegRsv3, 2), SizeHalf, 32'h1234_5678);
    bus_op(FuncRead, reg_address(2, RegRsv2, 0), SizeWord, '0);
    bus_op(FuncWrite, reg_address(6, RegDir, 0), SizeWord, 32'hFFFF_FFFF);
    bus_op(FuncRead, reg_address(7, RegPin, 0), SizeWord, '0);
  endtask

  // Board-driven pads on port 3 keep showing the pad level as outputs.
  task automatic test_board_pads();
    bus_op(FuncWrite, reg_address(3, RegDir, 0), SizeWord, 32'hFFFF_FFFF);
    bus_op(FuncWrite, reg_address(3, RegPin, 0), SizeWord, 32'h1234_5678);
    bus_op(FuncRead, reg_address(3, RegPin, 0), SizeWord, '0);
  endtask

  // Pad events that change a level, repeat it, or target a missing port.
  task automatic test_pad_events();
    pad_op(3'd4, 5'd31, 1'b0);
    pad_op(3'd4, 5'd31, 1'b0);
    pad_op(3'd7, 5'd0, 1'b0);
    pad_op(3'd0, 5'd7, 1'b1);
    bus_op(FuncRead, reg_address(0, RegSet, 0), SizeWord, '0);
    bus_op(FuncSpare, reg_address(0, RegDir, 0), SizeWord, 32'hFFFF_FFFF);
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    logic [2:0]  reg_idx;
    r    = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 40) r.func = FuncRead;
    else if (pick < 75) r.func = FuncWrite;
    else if (pick < 92) r.func = FuncPad;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 9))
        0, 1:    reg_idx = RegDir;
        2:       reg_idx = RegMask;
        3, 4:    reg_idx = RegPin;
        5, 6:    reg_idx = RegSet;
        7, 8:    reg_idx = RegClr;
        default: reg_idx = 3'($urandom_range(RegRsv1, RegRsv3));
      endcase
      r.bus_address = reg_address($urandom_range(0, NumPorts - 1), reg_idx,
                                  2'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 2))
        0:       r.access_size = SizeByte;
        1:       r.access_size = SizeHalf;
        default: r.access_size = SizeWord;
      endcase
    end
    if ($urandom_range(0, 9) == 0) r.write_data = $urandom_range(0, 1) ? '1 : '0;
    // Keep masks sparse so that most pin writes land.
    if (r.bus_address[4:2] == RegMask) r.write_data = r.write_data & $urandom;
    if ($urandom_range(0, 9) != 0) r.pad_port = 3'($urandom_range(0, NumPorts - 1));
    return r;
  endfunction

  task automatic test_random_traffic();
    req_t r;
    repeat (RandomItems) begin
      r = random_request();
      send_request(r);
    end
  endtask

  // Result checker: one prediction per strobed result, in order.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      n_results++;
      if (pending_rsps.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_rsps.pop_front();
        if (want.change_notify) n_notifies++;
        if (want.bad_offset) n_bad_writes++;
        if (read_data_o !== want.read_data)
          report_mismatch($sformatf("read_data %h, expected %h", read_data_o, want.read_data));
        if (change_notify_o !== want.change_notify)
          report_mismatch($sformatf("change_notify %b, expected %b", change_notify_o,
                                    want.change_notify));
        if (bad_offset_o !== want.bad_offset)
          report_mismatch($sformatf("bad_offset %b, expected %b", bad_offset_o,
                                    want.bad_offset));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("Watchdog expired with %0d results outstanding.", pending_rsps.size());
      $display("FAIL gpio_port_register_block_core");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    for (int p = 0; p < MaxPorts; p++) begin
      dir_words[p]   = '0;
      mask_words[p]  = '0;
      out_latches[p] = '0;
      pad_words[p]   = PadPullups[p];
    end
    burst_left = $urandom_range(1, 8);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_lanes_and_mask();
    test_reserved_and_ports();
    test_board_pads();
    test_pad_events();
    test_random_traffic();

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests: %0d reads, %0d writes, %0d pad events.",
             n_requests, n_reads, n_writes, n_pad_events);
    $display("Checked %0d results with %0d change pulses and %0d reserved writes; %0d errors.",
             n_results, n_notifies, n_bad_writes, n_errors);
    if (n_errors == 0) begin
      $display("PASS gpio_port_register_block_core");
    end else begin
      $display("FAIL gpio_port_register_block_core");
    end
    $finish;
  end

endmodule
